// ===== rtl/core/gdr_pkg.sv =====
// Shared types, constants and command codes of the grid DDA column raycaster.
package gdr_pkg;

  localparam int MAP_DIM    = 64;
  localparam int MAP_BITS   = $clog2(MAP_DIM);
  localparam int MAP_DEPTH  = MAP_DIM * MAP_DIM;
  localparam int MAX_STEPS  = 128;
  localparam int STEP_W     = $clog2(MAX_STEPS);
  localparam int MAX_SCREEN = 1024;

  localparam int CAM_W = 16;
  localparam int VEC_W = 16;
  localparam int DIM_W = 11;
  localparam int COL_W = 10;
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  localparam int NUM_W  = 13;
  localparam int OPD_W  = 29;
  localparam int PROD_W = 2 * OPD_W;
  localparam int RAY_W  = 29;
  localparam int MAG_W  = 28;
  localparam int DVD_W  = 29;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int PP_W   = 46;
  localparam int POS_W  = MAP_BITS + 2;
  localparam int FRC_W  = 11;
  localparam int NUMD_W = 19;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [15:0] DIST_MAX = 16'hFFFF;

  localparam logic [IDX_W-1:0] REG_CAM_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAM_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIR_X  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIR_Y  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PL_X   = 3'd4;
  localparam logic [IDX_W-1:0] REG_PL_Y   = 3'd5;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd6;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd7;

  localparam logic FUNC_WRITE = 1'b0;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_CLEAR    = 5'd1;
  localparam logic [4:0] OP_WRITE    = 5'd2;
  localparam logic [4:0] OP_LOAD     = 5'd3;
  localparam logic [4:0] OP_MUL_RX   = 5'd4;
  localparam logic [4:0] OP_DIV_RX   = 5'd5;
  localparam logic [4:0] OP_SET_RX   = 5'd6;
  localparam logic [4:0] OP_MUL_RY   = 5'd7;
  localparam logic [4:0] OP_DIV_RY   = 5'd8;
  localparam logic [4:0] OP_SET_RY   = 5'd9;
  localparam logic [4:0] OP_INIT     = 5'd10;
  localparam logic [4:0] OP_MUL_A    = 5'd11;
  localparam logic [4:0] OP_MUL_B    = 5'd12;
  localparam logic [4:0] OP_SET_PB   = 5'd13;
  localparam logic [4:0] OP_STEP     = 5'd14;
  localparam logic [4:0] OP_READ     = 5'd15;
  localparam logic [4:0] OP_NEXT     = 5'd16;
  localparam logic [4:0] OP_DIV_DIST = 5'd17;
  localparam logic [4:0] OP_SET_DIST = 5'd18;
  localparam logic [4:0] OP_DIV_LH   = 5'd19;
  localparam logic [4:0] OP_SLICE    = 5'd20;
  localparam logic [4:0] OP_OUT      = 5'd21;

  typedef struct packed {
    logic             func;
    logic [5:0]       cell_col;
    logic [5:0]       cell_row;
    logic [1:0]       cell_kind;
    logic [COL_W-1:0] column;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] column_out;
    logic [1:0]       wall_kind;
    logic [15:0]      wall_distance;
    logic [9:0]       slice_top;
    logic [9:0]       slice_bottom;
  } out_item_t;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_map;
    logic cell_hit;
    logic step_last;
    logic dist_bad;
    logic dist_zero;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/gdr_ctrl.sv =====
// Sequencer that drives the raycaster datapath one command per cycle.
module gdr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          func,
  output logic          in_stall,
  input  gdr_pkg::stat_t stat,
  output gdr_pkg::cmd_t  cmd
);

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_MRX   = 5'd2;
  localparam logic [4:0] ST_DRX   = 5'd3;
  localparam logic [4:0] ST_WRX   = 5'd4;
  localparam logic [4:0] ST_MRY   = 5'd5;
  localparam logic [4:0] ST_DRY   = 5'd6;
  localparam logic [4:0] ST_WRY   = 5'd7;
  localparam logic [4:0] ST_INIT  = 5'd8;
  localparam logic [4:0] ST_MA    = 5'd9;
  localparam logic [4:0] ST_MB    = 5'd10;
  localparam logic [4:0] ST_PB    = 5'd11;
  localparam logic [4:0] ST_STEP  = 5'd12;
  localparam logic [4:0] ST_ADDR  = 5'd13;
  localparam logic [4:0] ST_TEST  = 5'd14;
  localparam logic [4:0] ST_DDIST = 5'd15;
  localparam logic [4:0] ST_WDIST = 5'd16;
  localparam logic [4:0] ST_SL    = 5'd17;
  localparam logic [4:0] ST_WLH   = 5'd18;
  localparam logic [4:0] ST_FIN   = 5'd19;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = gdr_pkg::OP_NONE;
    case (state)
      ST_CLEAR: begin
        cmd.op = gdr_pkg::OP_CLEAR;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (func == gdr_pkg::FUNC_WRITE) begin
            cmd.op = gdr_pkg::OP_WRITE;
          end else begin
            cmd.op = gdr_pkg::OP_LOAD;
            state_next = ST_MRX;
          end
        end
      end
      ST_MRX: begin
        cmd.op = gdr_pkg::OP_MUL_RX;
        state_next = ST_DRX;
      end
      ST_DRX: begin
        cmd.op = gdr_pkg::OP_DIV_RX;
        state_next = ST_WRX;
      end
      ST_WRX: begin
        if (!stat.div_busy) begin
          cmd.op = gdr_pkg::OP_SET_RX;
          state_next = ST_MRY;
        end
      end
      ST_MRY: begin
        cmd.op = gdr_pkg::OP_MUL_RY;
        state_next = ST_DRY;
      end
      ST_DRY: begin
        cmd.op = gdr_pkg::OP_DIV_RY;
        state_next = ST_WRY;
      end
      ST_WRY: begin
        if (!stat.div_busy) begin
          cmd.op = gdr_pkg::OP_SET_RY;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.op = gdr_pkg::OP_INIT;
        state_next = ST_MA;
      end
      ST_MA: begin
        cmd.op = gdr_pkg::OP_MUL_A;
        state_next = ST_MB;
      end
      ST_MB: begin
        cmd.op = gdr_pkg::OP_MUL_B;
        state_next = ST_PB;
      end
      ST_PB: begin
        cmd.op = gdr_pkg::OP_SET_PB;
        state_next = stat.in_map ? ST_STEP : ST_FIN;
      end
      ST_STEP: begin
        cmd.op = gdr_pkg::OP_STEP;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        if (stat.in_map) begin
          cmd.op = gdr_pkg::OP_READ;
          state_next = ST_TEST;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_TEST: begin
        cmd.op = gdr_pkg::OP_NEXT;
        if (stat.cell_hit) begin
          state_next = stat.dist_bad ? ST_SL : ST_DDIST;
        end else if (stat.step_last) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_DDIST: begin
        cmd.op = gdr_pkg::OP_DIV_DIST;
        state_next = ST_WDIST;
      end
      ST_WDIST: begin
        if (!stat.div_busy) begin
          cmd.op = gdr_pkg::OP_SET_DIST;
          state_next = ST_SL;
        end
      end
      ST_SL: begin
        if (stat.dist_zero) begin
          cmd.op = gdr_pkg::OP_SLICE;
          state_next = ST_FIN;
        end else begin
          cmd.op = gdr_pkg::OP_DIV_LH;
          state_next = ST_WLH;
        end
      end
      ST_WLH: begin
        if (!stat.div_busy) begin
          cmd.op = gdr_pkg::OP_SLICE;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.op = gdr_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/gdr_datapath.sv =====
// Registers, map memory, shared multiplier and divider of the raycaster.
module gdr_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gdr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [gdr_pkg::CFG_W-1:0]      cfg_data,
  input  gdr_pkg::in_item_t              in_data,
  input  gdr_pkg::cmd_t                  cmd,
  output gdr_pkg::stat_t                 stat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gdr_pkg::out_item_t             out_data
);

  logic [gdr_pkg::CAM_W-1:0] cam_x, cam_y;
  logic signed [gdr_pkg::VEC_W-1:0] dir_x, dir_y, pl_x, pl_y;
  logic [gdr_pkg::DIM_W-1:0] scr_w, scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= 16'd32768;
      cam_y <= 16'd32768;
      dir_x <= 16'sd16384;
      dir_y <= 16'sd0;
      pl_x  <= 16'sd0;
      pl_y  <= 16'sd16384;
      scr_w <= 11'd80;
      scr_h <= 11'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        gdr_pkg::REG_CAM_X:  cam_x <= cfg_data;
        gdr_pkg::REG_CAM_Y:  cam_y <= cfg_data;
        gdr_pkg::REG_DIR_X:  dir_x <= $signed(cfg_data);
        gdr_pkg::REG_DIR_Y:  dir_y <= $signed(cfg_data);
        gdr_pkg::REG_PL_X:   pl_x  <= $signed(cfg_data);
        gdr_pkg::REG_PL_Y:   pl_y  <= $signed(cfg_data);
        gdr_pkg::REG_WIDTH:  scr_w <= cfg_data[gdr_pkg::DIM_W-1:0];
        gdr_pkg::REG_HEIGHT: scr_h <= cfg_data[gdr_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  function automatic logic [gdr_pkg::DIM_W-1:0] clamp_dim(input logic [gdr_pkg::DIM_W-1:0] v);
    logic [gdr_pkg::DIM_W-1:0] r;
    r = v;
    if (v == '0) r = gdr_pkg::DIM_W'(1);
    if (v > gdr_pkg::DIM_W'(gdr_pkg::MAX_SCREEN)) r = gdr_pkg::DIM_W'(gdr_pkg::MAX_SCREEN);
    return r;
  endfunction

  logic [gdr_pkg::DIM_W-1:0] w_clamp, w_eff, h_eff;
  logic [gdr_pkg::COL_W-1:0] col;
  logic signed [gdr_pkg::NUM_W-1:0] num_r;
  logic signed [gdr_pkg::PROD_W-1:0] prod;
  logic [gdr_pkg::PROD_W-1:0] prod_mag;
  logic ray_neg;
  logic signed [gdr_pkg::RAY_W-1:0] rx, ry, ray_val;
  logic [gdr_pkg::MAG_W-1:0] ax, ay;
  logic signed [gdr_pkg::POS_W-1:0] x, y;
  logic sgx_neg, sgy_neg, xside, xside_now;
  logic [gdr_pkg::PP_W-1:0] pa, pb;
  logic [gdr_pkg::FRC_W-1:0] a0, b0;
  logic [gdr_pkg::STEP_W-1:0] steps;
  logic [1:0] kind;
  logic [15:0] wall_dist;
  logic [9:0] top, bottom;

  assign w_clamp = clamp_dim(scr_w);

  // Shared multiplier.
  logic signed [gdr_pkg::OPD_W-1:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      gdr_pkg::OP_MUL_RX: begin
        ma = gdr_pkg::OPD_W'(pl_x);
        mb = gdr_pkg::OPD_W'(num_r);
      end
      gdr_pkg::OP_MUL_RY: begin
        ma = gdr_pkg::OPD_W'(pl_y);
        mb = gdr_pkg::OPD_W'(num_r);
      end
      gdr_pkg::OP_MUL_A: begin
        ma = $signed({{(gdr_pkg::OPD_W-gdr_pkg::FRC_W){1'b0}}, a0});
        mb = $signed({1'b0, ay});
      end
      gdr_pkg::OP_MUL_B: begin
        ma = $signed({{(gdr_pkg::OPD_W-gdr_pkg::FRC_W){1'b0}}, b0});
        mb = $signed({1'b0, ax});
      end
      default: begin
      end
    endcase
  end

  assign prod_mag = prod[gdr_pkg::PROD_W-1] ? $unsigned(-prod) : $unsigned(prod);

  // Restoring divider, one quotient bit per cycle.
  logic [gdr_pkg::DVD_W-1:0] quo, dvd_in;
  logic [gdr_pkg::MAG_W-1:0] rem, dvs, dvs_in;
  logic [gdr_pkg::CNT_W-1:0] div_cnt;
  logic div_busy, div_start;
  logic [gdr_pkg::MAG_W:0] rem_sh, rem_try;

  logic signed [gdr_pkg::POS_W-1:0] edge_cell;
  logic signed [gdr_pkg::NUMD_W-1:0] dnum;
  logic [gdr_pkg::MAG_W-1:0] dmag;

  always_comb begin
    if (xside) begin
      edge_cell = sgx_neg ? x + gdr_pkg::POS_W'(1) : x;
      dnum = gdr_pkg::NUMD_W'({edge_cell, 10'b0}) - $signed({3'b0, cam_x});
      dmag = ax;
    end else begin
      edge_cell = sgy_neg ? y + gdr_pkg::POS_W'(1) : y;
      dnum = gdr_pkg::NUMD_W'({edge_cell, 10'b0}) - $signed({3'b0, cam_y});
      dmag = ay;
    end
  end

  always_comb begin
    div_start = 1'b1;
    dvd_in = '0;
    dvs_in = '0;
    case (cmd.op)
      gdr_pkg::OP_DIV_RX, gdr_pkg::OP_DIV_RY: begin
        dvd_in = prod_mag[gdr_pkg::DVD_W-1:0];
        dvs_in = gdr_pkg::MAG_W'(w_eff);
      end
      gdr_pkg::OP_DIV_DIST: begin
        dvd_in = {dnum[16:0], 12'b0};
        dvs_in = dmag;
      end
      gdr_pkg::OP_DIV_LH: begin
        dvd_in = gdr_pkg::DVD_W'({h_eff, 8'b0});
        dvs_in = gdr_pkg::MAG_W'(wall_dist);
      end
      default: div_start = 1'b0;
    endcase
  end

  assign rem_sh  = {rem, quo[gdr_pkg::DVD_W-1]};
  assign rem_try = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= gdr_pkg::CNT_W'(gdr_pkg::DVD_W);
    end else if (div_busy) begin
      div_cnt <= div_cnt - gdr_pkg::CNT_W'(1);
      if (div_cnt == gdr_pkg::CNT_W'(1)) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      quo <= dvd_in;
      rem <= '0;
      dvs <= dvs_in;
    end else if (div_busy) begin
      if (!rem_try[gdr_pkg::MAG_W]) begin
        rem <= rem_try[gdr_pkg::MAG_W-1:0];
        quo <= {quo[gdr_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[gdr_pkg::MAG_W-1:0];
        quo <= {quo[gdr_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  // Map memory and its clearing pass.
  logic [1:0] mem [gdr_pkg::MAP_DEPTH];
  logic [2*gdr_pkg::MAP_BITS-1:0] clr_addr, waddr;
  logic [1:0] wdata, rdata;
  logic mem_we;

  always_comb begin
    mem_we = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (cmd.op == gdr_pkg::OP_CLEAR) begin
      mem_we = 1'b1;
    end else if (cmd.op == gdr_pkg::OP_WRITE) begin
      mem_we = 1'b1;
      waddr = {in_data.cell_row[gdr_pkg::MAP_BITS-1:0],
               in_data.cell_col[gdr_pkg::MAP_BITS-1:0]};
      wdata = in_data.cell_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == gdr_pkg::OP_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[{y[gdr_pkg::MAP_BITS-1:0], x[gdr_pkg::MAP_BITS-1:0]}];
  end

  assign ray_val = ray_neg ? -$signed(quo) : $signed(quo);
  assign xside_now = (pa < pb);

  always_ff @(posedge clk) begin
    case (cmd.op)
      gdr_pkg::OP_LOAD: begin
        col       <= in_data.column;
        w_eff     <= w_clamp;
        h_eff     <= clamp_dim(scr_h);
        num_r     <= $signed({2'b0, in_data.column, 1'b0}) - $signed({2'b0, w_clamp});
        kind      <= gdr_pkg::KIND_NONE;
        wall_dist <= gdr_pkg::DIST_MAX;
        top       <= '0;
        bottom    <= '0;
      end
      gdr_pkg::OP_MUL_RX, gdr_pkg::OP_MUL_RY, gdr_pkg::OP_MUL_A: begin
        prod <= ma * mb;
      end
      gdr_pkg::OP_MUL_B: begin
        prod <= ma * mb;
        pa   <= prod[gdr_pkg::PP_W-1:0];
      end
      gdr_pkg::OP_DIV_RX, gdr_pkg::OP_DIV_RY: begin
        ray_neg <= prod[gdr_pkg::PROD_W-1];
      end
      gdr_pkg::OP_SET_RX: begin
        rx <= gdr_pkg::RAY_W'(dir_x) + ray_val;
      end
      gdr_pkg::OP_SET_RY: begin
        ry <= gdr_pkg::RAY_W'(dir_y) + ray_val;
      end
      gdr_pkg::OP_INIT: begin
        sgx_neg <= rx[gdr_pkg::RAY_W-1];
        sgy_neg <= ry[gdr_pkg::RAY_W-1];
        ax <= rx[gdr_pkg::RAY_W-1] ? gdr_pkg::MAG_W'(-rx) : gdr_pkg::MAG_W'(rx);
        ay <= ry[gdr_pkg::RAY_W-1] ? gdr_pkg::MAG_W'(-ry) : gdr_pkg::MAG_W'(ry);
        a0 <= rx[gdr_pkg::RAY_W-1] ? {1'b0, cam_x[9:0]} : 11'd1024 - {1'b0, cam_x[9:0]};
        b0 <= ry[gdr_pkg::RAY_W-1] ? {1'b0, cam_y[9:0]} : 11'd1024 - {1'b0, cam_y[9:0]};
        x  <= gdr_pkg::POS_W'(cam_x[15:10]);
        y  <= gdr_pkg::POS_W'(cam_y[15:10]);
        steps <= '0;
      end
      gdr_pkg::OP_SET_PB: begin
        pb <= prod[gdr_pkg::PP_W-1:0];
      end
      gdr_pkg::OP_STEP: begin
        xside <= xside_now;
        if (xside_now) begin
          pa <= pa + gdr_pkg::PP_W'({ay, 10'b0});
          x  <= sgx_neg ? x - gdr_pkg::POS_W'(1) : x + gdr_pkg::POS_W'(1);
        end else begin
          pb <= pb + gdr_pkg::PP_W'({ax, 10'b0});
          y  <= sgy_neg ? y - gdr_pkg::POS_W'(1) : y + gdr_pkg::POS_W'(1);
        end
      end
      gdr_pkg::OP_NEXT: begin
        steps <= steps + 1'b1;
        if (rdata != 2'd0) kind <= rdata - 2'd1;
      end
      gdr_pkg::OP_SET_DIST: begin
        wall_dist <= (quo > gdr_pkg::DVD_W'(gdr_pkg::DIST_MAX)) ? gdr_pkg::DIST_MAX : quo[15:0];
      end
      gdr_pkg::OP_SLICE: begin
        if (wall_dist == 16'd0) begin
          top    <= '0;
          bottom <= 10'(h_eff - 1'b1);
        end else begin
          if ({9'b0, quo[18:1]} > gdr_pkg::DVD_W'(h_eff[10:1])) top <= '0;
          else top <= 10'(h_eff[10:1] - quo[10:1]);
          if (gdr_pkg::DVD_W'(h_eff[10:1]) + {11'b0, quo[18:1]} > gdr_pkg::DVD_W'(h_eff - 1'b1))
            bottom <= 10'(h_eff - 1'b1);
          else bottom <= 10'(h_eff[10:1] + quo[10:1]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == gdr_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gdr_pkg::OP_OUT) begin
      out_data.column_out    <= col;
      out_data.wall_kind     <= kind;
      out_data.wall_distance <= wall_dist;
      out_data.slice_top     <= top;
      out_data.slice_bottom  <= bottom;
    end
  end

  assign stat.clear_last = (clr_addr == '1);
  assign stat.in_map     = !x[gdr_pkg::POS_W-1] && !y[gdr_pkg::POS_W-1] &&
                           (x < gdr_pkg::POS_W'(gdr_pkg::MAP_DIM)) &&
                           (y < gdr_pkg::POS_W'(gdr_pkg::MAP_DIM));
  assign stat.cell_hit   = (rdata != 2'd0);
  assign stat.step_last  = (steps == gdr_pkg::STEP_W'(gdr_pkg::MAX_STEPS - 1));
  assign stat.dist_bad   = (dmag == '0) || dnum[gdr_pkg::NUMD_W-1];
  assign stat.dist_zero  = (wall_dist == 16'd0);
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

// ===== rtl/core/grid_dda_column_raycaster_unit.sv =====
// Top level of the grid DDA column raycaster: sequencer plus datapath.
//
//   Channel  Direction  Transfer when          Payload
//   in       input      in_valid && !in_stall  in_data (gdr_pkg::in_item_t)
//   out      output     out_valid && !out_stall out_data (gdr_pkg::out_item_t)
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// A cast makes up to four passes through the shared divider and reads the
// one-read-a-cycle map memory once per grid step. After reset a clearing
// pass over all 4096 cells empties the map; no item is taken meanwhile. A
// result waiting in the output register does not block new input; a
// finished cast waits for it to leave.
module grid_dda_column_raycaster_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  gdr_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output gdr_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [gdr_pkg::IDX_W-1:0] cfg_index,
  input  logic [gdr_pkg::CFG_W-1:0] cfg_data
);

  gdr_pkg::cmd_t  cmd;
  gdr_pkg::stat_t stat;

  gdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (in_data.func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gdr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the grid DDA column raycaster: map writes, casts and register changes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  class cast_scoreboard;
    logic [15:0] cam_x, cam_y, dir_x, dir_y, pl_x, pl_y;
    logic [10:0] width, height;
    logic [1:0] cells [gdr_pkg::MAP_DEPTH];
    gdr_pkg::out_item_t pending_casts [$];
    int errors;

    function new();
      cam_x = 16'd32768;
      cam_y = 16'd32768;
      dir_x = 16'd16384;
      dir_y = 16'd0;
      pl_x = 16'd0;
      pl_y = 16'd16384;
      width = 11'd80;
      height = 11'd25;
      foreach (cells[i]) cells[i] = 2'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [gdr_pkg::IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        gdr_pkg::REG_CAM_X: cam_x = v;
        gdr_pkg::REG_CAM_Y: cam_y = v;
        gdr_pkg::REG_DIR_X: dir_x = v;
        gdr_pkg::REG_DIR_Y: dir_y = v;
        gdr_pkg::REG_PL_X: pl_x = v;
        gdr_pkg::REG_PL_Y: pl_y = v;
        gdr_pkg::REG_WIDTH: width = v[10:0];
        default: height = v[10:0];
      endcase
    endfunction

    function longint dim_of(logic [10:0] v);
      longint d;
      d = v;
      if (d < 1) d = 1;
      if (d > gdr_pkg::MAX_SCREEN) d = gdr_pkg::MAX_SCREEN;
      return d;
    endfunction

    function longint perp(longint num, longint mag);
      longint q;
      if (mag == 0 || num < 0) return 65535;
      q = (num * 4096) / mag;
      return q > 65535 ? 65535 : q;
    endfunction

    function void note_input(gdr_pkg::in_item_t it);
      longint w, h, nr, rx, ry, x, y, px, py, sgx, sgy, ax, ay, fa, fb, wall_dist, lh, s, e;
      logic [1:0] kind, c;
      logic xside;
      gdr_pkg::out_item_t r;
      if (it.func == gdr_pkg::FUNC_WRITE) begin
        cells[{it.cell_row, it.cell_col}] = it.cell_kind;
        return;
      end
      w = dim_of(width);
      h = dim_of(height);
      nr = 2 * longint'(it.column) - w;
      rx = longint'($signed(dir_x)) + (longint'($signed(pl_x)) * nr) / w;
      ry = longint'($signed(dir_y)) + (longint'($signed(pl_y)) * nr) / w;
      px = cam_x;
      py = cam_y;
      x = px >>> 10;
      y = py >>> 10;
      sgx = rx < 0 ? -1 : 1;
      sgy = ry < 0 ? -1 : 1;
      ax = rx < 0 ? -rx : rx;
      ay = ry < 0 ? -ry : ry;
      fa = rx < 0 ? (px & 1023) : 1024 - (px & 1023);
      fb = ry < 0 ? (py & 1023) : 1024 - (py & 1023);
      kind = gdr_pkg::KIND_NONE;
      wall_dist = 65535;
      if (x < gdr_pkg::MAP_DIM && y < gdr_pkg::MAP_DIM) begin
        for (int n = 0; n < gdr_pkg::MAX_STEPS; n++) begin
          xside = fa * ay < fb * ax;
          if (xside) begin
            fa += 1024;
            x += sgx;
          end else begin
            fb += 1024;
            y += sgy;
          end
          if (x < 0 || x >= gdr_pkg::MAP_DIM || y < 0 || y >= gdr_pkg::MAP_DIM) break;
          c = cells[y * gdr_pkg::MAP_DIM + x];
          if (c != 2'd0) begin
            if (xside) wall_dist = perp(sgx > 0 ? x * 1024 - px : (x + 1) * 1024 - px, ax);
            else wall_dist = perp(sgy > 0 ? y * 1024 - py : (y + 1) * 1024 - py, ay);
            kind = c - 2'd1;
            break;
          end
        end
      end
      r.column_out = it.column;
      r.wall_kind = kind;
      r.wall_distance = wall_dist[15:0];
      r.slice_top = '0;
      r.slice_bottom = '0;
      if (kind != gdr_pkg::KIND_NONE) begin
        if (wall_dist == 0) begin
          r.slice_bottom = 10'(h - 1);
        end else begin
          lh = (h * 256) / wall_dist;
          s = h / 2 - lh / 2;
          e = h / 2 + lh / 2;
          if (s < 0) s = 0;
          if (e > h - 1) e = h - 1;
          r.slice_top = s[9:0];
          r.slice_bottom = e[9:0];
        end
      end
      pending_casts.push_back(r);
    endfunction

    function void check_result(gdr_pkg::out_item_t got);
      gdr_pkg::out_item_t exp;
      if (pending_casts.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      exp = pending_casts.pop_front();
      if (got.column_out !== exp.column_out)
        $display("%0t: column_out expected %0d actual %0d", $time, exp.column_out,
                 got.column_out);
      if (got.wall_kind !== exp.wall_kind)
        $display("%0t: wall_kind expected %0d actual %0d", $time, exp.wall_kind,
                 got.wall_kind);
      if (got.wall_distance !== exp.wall_distance)
        $display("%0t: wall_distance expected %0d actual %0d", $time, exp.wall_distance,
                 got.wall_distance);
      if (got.slice_top !== exp.slice_top)
        $display("%0t: slice_top expected %0d actual %0d", $time, exp.slice_top,
                 got.slice_top);
      if (got.slice_bottom !== exp.slice_bottom)
        $display("%0t: slice_bottom expected %0d actual %0d", $time, exp.slice_bottom,
                 got.slice_bottom);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  gdr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gdr_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [gdr_pkg::IDX_W-1:0] cfg_index = '0;
  logic [gdr_pkg::CFG_W-1:0] cfg_data = '0;

  cast_scoreboard board = new();
  bit quiet_tail = 1'b0;
  int idle_cycles = 0;

  grid_dda_column_raycaster_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls in short random bursts.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Valid stays high after a transfer; a drain, or a random gap in the next call, takes it down.
  task automatic send_item(gdr_pkg::in_item_t it);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_casts.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [gdr_pkg::IDX_W-1:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic put_cell(int cx, int cy, logic [1:0] k);
    gdr_pkg::in_item_t it;
    it = '0;
    it.func = gdr_pkg::FUNC_WRITE;
    it.cell_col = 6'(cx);
    it.cell_row = 6'(cy);
    it.cell_kind = k;
    send_item(it);
  endtask

  task automatic cast(logic [9:0] c);
    gdr_pkg::in_item_t it;
    it = gdr_pkg::in_item_t'($urandom);
    it.func = ~gdr_pkg::FUNC_WRITE;
    it.column = c;
    send_item(it);
  endtask

  task automatic random_view();
    write_reg(gdr_pkg::REG_CAM_X, 16'($urandom_range(4 * 1024, 60 * 1024)));
    write_reg(gdr_pkg::REG_CAM_Y, 16'($urandom_range(4 * 1024, 60 * 1024)));
    write_reg(gdr_pkg::REG_DIR_X, 16'($urandom_range(0, 65535)));
    write_reg(gdr_pkg::REG_DIR_Y, 16'($urandom_range(0, 65535)));
    write_reg(gdr_pkg::REG_PL_X, 16'($urandom_range(0, 65535)));
    write_reg(gdr_pkg::REG_PL_Y, 16'($urandom_range(0, 65535)));
    write_reg(gdr_pkg::REG_WIDTH, 16'($urandom_range(0, 2047)));
    write_reg(gdr_pkg::REG_HEIGHT, 16'($urandom_range(0, 2047)));
  endtask

  initial begin
    gdr_pkg::in_item_t it;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    cast(10'd40);
    for (int i = 0; i < gdr_pkg::MAP_DIM; i++) begin
      put_cell(i, 0, 2'd1);
      put_cell(i, 63, 2'd2);
      put_cell(0, i, 2'd3);
      put_cell(63, i, 2'd1);
    end
    cast(10'd0);
    cast(10'd40);
    cast(10'd79);
    cast(10'd1023);
    put_cell(33, 32, 2'd2);
    cast(10'd40);
    drain();
    write_reg(gdr_pkg::REG_DIR_X, 16'd0);
    write_reg(gdr_pkg::REG_DIR_Y, 16'd0);
    write_reg(gdr_pkg::REG_PL_X, 16'd0);
    write_reg(gdr_pkg::REG_PL_Y, 16'd0);
    write_reg(gdr_pkg::REG_WIDTH, 16'd0);
    write_reg(gdr_pkg::REG_HEIGHT, 16'd0);
    cast(10'd0);
    drain();
    write_reg(gdr_pkg::REG_DIR_X, 16'h8000);
    write_reg(gdr_pkg::REG_DIR_Y, 16'h7FFF);
    write_reg(gdr_pkg::REG_PL_X, 16'h7FFF);
    write_reg(gdr_pkg::REG_PL_Y, 16'h8000);
    write_reg(gdr_pkg::REG_WIDTH, 16'd2047);
    write_reg(gdr_pkg::REG_HEIGHT, 16'd2047);
    write_reg(gdr_pkg::REG_CAM_X, 16'hFFFF);
    write_reg(gdr_pkg::REG_CAM_Y, 16'h0000);
    cast(10'd512);
    drain();
    write_reg(gdr_pkg::REG_CAM_X, 16'd33 * 1024);
    write_reg(gdr_pkg::REG_CAM_Y, 16'd32 * 1024 + 16'd512);
    write_reg(gdr_pkg::REG_DIR_X, 16'hC000);
    write_reg(gdr_pkg::REG_DIR_Y, 16'd0);
    cast(10'd0);
    cast(10'd1023);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      random_view();
      if (phase == 11) quiet_tail = 1'b1;
      for (int k = 0; k < 105; k++) begin
        it = gdr_pkg::in_item_t'($urandom);
        if ($urandom_range(0, 2) == 0) it.func = gdr_pkg::FUNC_WRITE;
        else it.func = ~gdr_pkg::FUNC_WRITE;
        if (it.func == gdr_pkg::FUNC_WRITE && $urandom_range(0, 1) == 0) it.cell_kind = 2'd0;
        if (it.func != gdr_pkg::FUNC_WRITE && $urandom_range(0, 3) != 0)
          it.column = 10'($urandom_range(0, 1023) % board.dim_of(board.width));
        send_item(it);
        if (k == 60 && phase == 3) drain();
      end
      drain();
    end

    if (board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/gdr_pkg.sv
rtl/core/gdr_ctrl.sv
rtl/core/gdr_datapath.sv
rtl/core/grid_dda_column_raycaster_unit.sv
test/tb.sv
